FILE: sv/bnms_pkg.sv
package bnms_pkg;

  // per-cell control from the sequencer
  typedef struct packed {
    logic shift;   // ring rotates one place
    logic load;    // capture a new box
    logic kill;    // frame end: drop the box
    logic wb;      // take the overlap unit's alive verdict while shifting
  } cell_ctrl_t;

  localparam logic [15:0] THRESH_RESET = 16'd19661;
  localparam int          PIPE_DEPTH   = 4;   // register stages in the overlap unit
  localparam int          COORD_W      = 12;
  localparam int          SCORE_W      = 16;
  localparam int          KIDX_W       = 5;

endpackage

FILE: sv/bnms_if.sv
interface bnms_in_if;
  logic        valid;
  logic        ready;
  logic [11:0] box_x;
  logic [11:0] box_y;
  logic [11:0] box_w;
  logic [11:0] box_h;
  logic [15:0] score;
  logic        present;
  logic        last_box;
  modport source (output valid, box_x, box_y, box_w, box_h, score, present, last_box,
                  input ready);
  modport sink (input valid, box_x, box_y, box_w, box_h, score, present, last_box,
                output ready);
endinterface

interface bnms_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] kept_x;
  logic [11:0] kept_y;
  logic [11:0] kept_w;
  logic [11:0] kept_h;
  logic [15:0] kept_score;
  logic [4:0]  kept_index;
  logic        none_kept;
  logic        overflow;
  logic        last_kept;
  modport source (output valid, kept_x, kept_y, kept_w, kept_h, kept_score, kept_index,
                  none_kept, overflow, last_kept, input ready);
  modport sink (input valid, kept_x, kept_y, kept_w, kept_h, kept_score, kept_index,
                none_kept, overflow, last_kept, output ready);
endinterface

interface bnms_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

FILE: sv/bnms_cell.sv
module bnms_cell #(
  parameter int W = 78
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  bnms_pkg::cell_ctrl_t  ctrl,
  input  logic [W-1:0]          load_data,
  input  logic [W-1:0]          nbr_data,
  input  logic                  nbr_alive,
  input  logic                  wb_alive,
  output logic [W-1:0]          data,
  output logic                  alive
);
  import bnms_pkg::*;

  logic [W-1:0] data_r, data_nxt;
  logic         alive_r, alive_nxt;

  always_comb begin
    data_nxt  = data_r;
    alive_nxt = alive_r;
    if (ctrl.kill) begin
      alive_nxt = 1'b0;
    end else if (ctrl.load) begin
      data_nxt  = load_data;
      alive_nxt = 1'b1;
    end else if (ctrl.shift) begin
      data_nxt  = nbr_data;
      alive_nxt = ctrl.wb ? wb_alive : nbr_alive;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alive_r <= 1'b0;
    end else begin
      alive_r <= alive_nxt;
    end
    data_r <= data_nxt;
  end

  assign data  = data_r;
  assign alive = alive_r;

endmodule

FILE: sv/bnms_ovl.sv
module bnms_ovl #(
  parameter int C  = 12,
  parameter int IW = 5
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic [4*C+15+IW:0]        cand,
  input  logic                      cand_alive,
  input  logic [4*C+15+IW:0]        kept,
  input  logic                      has_kept,
  input  logic [15:0]               thr,
  output logic                      vld,
  output logic [4*C+15+IW:0]        data,
  output logic                      keep_alive
);
  import bnms_pkg::*;

  localparam int W = 4*C + 16 + IW;
  localparam int H = C + 1;

  // box word layout: {x, y, w, h, score, idx}
  logic [C-1:0]  cx, cy, kx, ky, kw, kh;
  logic [C-1:0]  cwid, chgt;
  logic [IW-1:0] cidx, kidx;
  logic [C:0]    ax1, bx1, ay1, by1, x0, x1, y0, y1;

  assign cx   = cand[W-1 -: C];
  assign cy   = cand[W-1-C -: C];
  assign cidx = cand[IW-1:0];
  assign kx   = kept[W-1 -: C];
  assign ky   = kept[W-1-C -: C];
  assign kw   = kept[W-1-2*C -: C];
  assign kh   = kept[W-1-3*C -: C];
  assign kidx = kept[IW-1:0];
  assign cwid = cand[W-1-2*C -: C];
  assign chgt = cand[W-1-3*C -: C];

  always_comb begin
    ax1 = {1'b0, kx} + {1'b0, kw};
    bx1 = {1'b0, cx} + {1'b0, cwid};
    ay1 = {1'b0, ky} + {1'b0, kh};
    by1 = {1'b0, cy} + {1'b0, chgt};
    x0  = (kx > cx) ? {1'b0, kx} : {1'b0, cx};
    y0  = (ky > cy) ? {1'b0, ky} : {1'b0, cy};
    x1  = (ax1 < bx1) ? ax1 : bx1;
    y1  = (ay1 < by1) ? ay1 : by1;
  end

  // stage 1: intersection extents
  logic          s1_vld_r, s1_alive_r, s1_ov_r, s1_self_r;
  logic [W-1:0]  s1_data_r;
  logic [C:0]    s1_dx_r, s1_dy_r;
  // stage 2: products
  logic          s2_vld_r, s2_alive_r, s2_ov_r, s2_self_r;
  logic [W-1:0]  s2_data_r;
  logic [2*H-1:0] s2_inter_r;
  logic [2*C-1:0] s2_aa_r, s2_ab_r;
  // stage 3: union
  logic          s3_vld_r, s3_alive_r, s3_ov_r, s3_self_r;
  logic [W-1:0]  s3_data_r;
  logic [2*H-1:0] s3_inter_r, s3_uni_r;
  // stage 4: threshold * union in two halves
  logic          s4_vld_r, s4_alive_r, s4_ov_r, s4_self_r;
  logic [W-1:0]  s4_data_r;
  logic [2*H-1:0] s4_inter_r;
  logic [15+H:0]  s4_plo_r, s4_phi_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= en;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
      s4_vld_r <= s3_vld_r;
    end
    s1_data_r  <= cand;
    s1_alive_r <= cand_alive;
    s1_ov_r    <= has_kept && (x1 > x0) && (y1 > y0);
    s1_self_r  <= has_kept && (cidx == kidx);
    s1_dx_r    <= x1 - x0;
    s1_dy_r    <= y1 - y0;

    s2_data_r  <= s1_data_r;
    s2_alive_r <= s1_alive_r;
    s2_ov_r    <= s1_ov_r;
    s2_self_r  <= s1_self_r;
    s2_inter_r <= s1_dx_r * s1_dy_r;
    s2_ab_r    <= s1_data_r[W-1-2*C -: C] * s1_data_r[W-1-3*C -: C];
    s2_aa_r    <= kw * kh;

    s3_data_r  <= s2_data_r;
    s3_alive_r <= s2_alive_r;
    s3_ov_r    <= s2_ov_r;
    s3_self_r  <= s2_self_r;
    s3_inter_r <= s2_inter_r;
    s3_uni_r   <= {2'b00, s2_aa_r} + {2'b00, s2_ab_r} - s2_inter_r;

    s4_data_r  <= s3_data_r;
    s4_alive_r <= s3_alive_r;
    s4_ov_r    <= s3_ov_r;
    s4_self_r  <= s3_self_r;
    s4_inter_r <= s3_inter_r;
    s4_plo_r   <= thr * s3_uni_r[H-1:0];
    s4_phi_r   <= thr * s3_uni_r[2*H-1:H];
  end

  logic [2*H+15:0] lhs, rhs;
  logic            over;

  always_comb begin
    lhs  = {s4_inter_r, 16'h0000};
    rhs  = {s4_phi_r, {H{1'b0}}} + {{H{1'b0}}, s4_plo_r};
    over = s4_ov_r && (lhs > rhs);
  end

  assign vld        = s4_vld_r;
  assign data       = s4_data_r;
  assign keep_alive = s4_alive_r && !s4_self_r && !over;

endmodule

FILE: sv/box_non_maximum_suppression.sv
// Load: one box per cycle, one transaction per cycle while loading.
// Suppression: the box ring rotates past a 4-stage overlap unit; each pass is
// followed by a decide step; a frame with K kept boxes needs K+1 passes.
// Results leave through an output register; rst_n (synchronous) clears the frame
// and sets the threshold to 0.3.
module box_non_maximum_suppression #(
  parameter int MAX_BOXES  = 32,
  parameter int COORD_BITS = 12
) (
  input  logic       clk,
  input  logic       rst_n,
  bnms_in_if.sink    in_ch,
  bnms_out_if.source out_ch,
  bnms_cfg_if.sink   cfg_ch
);
  import bnms_pkg::*;

  localparam int M         = MAX_BOXES;
  localparam int C         = COORD_BITS;
  localparam int IW        = $clog2(M);
  localparam int CW        = $clog2(M + 1);
  localparam int W         = 4*C + 16 + IW;
  localparam int WB        = (M - ((PIPE_DEPTH + 1) % M)) % M;
  localparam int SCAN_LAST = M + PIPE_DEPTH;
  localparam int NW        = $clog2(SCAN_LAST + 1);

  localparam logic [1:0] ST_LOAD   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_DECIDE = 2'd2;
  localparam logic [1:0] ST_NONE   = 2'd3;

  logic [1:0]    state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          ovf_r, ovf_nxt;
  logic [15:0]   thr_r;
  logic [NW-1:0] cnt_r, cnt_nxt;
  logic          has_kept_r, has_kept_nxt;
  logic [W-1:0]  kept_r, kept_nxt;
  logic          best_found_r, best_found_nxt;
  logic [W-1:0]  best_r, best_nxt;

  logic          out_valid_r;
  logic [11:0]   ox_r, oy_r, ow_r, oh_r;
  logic [15:0]   os_r;
  logic [4:0]    oi_r;
  logic          onone_r, oovf_r, olast_r;

  logic          in_acc, store, out_free;
  logic          push, push_none, push_last, clear, scan;
  logic [W-1:0]  load_word;

  logic [W-1:0]  cdata  [M];
  logic          calive [M];
  logic          ovl_vld, ovl_keep;
  logic [W-1:0]  ovl_data;

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign store    = in_acc && in_ch.present && (count_r < CW'(M));
  assign out_free = !out_valid_r || out_ch.ready;
  assign scan     = (state_r == ST_SCAN);

  assign load_word = {C'(in_ch.box_x), C'(in_ch.box_y), C'(in_ch.box_w),
                      C'(in_ch.box_h), in_ch.score, count_r[IW-1:0]};

  genvar gi;
  generate
    for (gi = 0; gi < M; gi++) begin : g_ring
      cell_ctrl_t ctrl;
      always_comb begin
        ctrl.shift = scan;
        ctrl.load  = store && (count_r[IW-1:0] == IW'(gi));
        ctrl.kill  = clear;
        ctrl.wb    = (gi == WB) && ovl_vld;
      end
      bnms_cell #(.W(W)) u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .load_data (load_word),
        .nbr_data  (cdata[(gi + 1) % M]),
        .nbr_alive (calive[(gi + 1) % M]),
        .wb_alive  (ovl_keep),
        .data      (cdata[gi]),
        .alive     (calive[gi])
      );
    end
  endgenerate

  bnms_ovl #(.C(C), .IW(IW)) u_ovl (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (scan && (cnt_r < NW'(M))),
    .cand       (cdata[0]),
    .cand_alive (calive[0]),
    .kept       (kept_r),
    .has_kept   (has_kept_r),
    .thr        (thr_r),
    .vld        (ovl_vld),
    .data       (ovl_data),
    .keep_alive (ovl_keep)
  );

  logic [15:0]   rs, bs;
  logic [IW-1:0] ri, bi;
  assign rs = ovl_data[IW+15 -: 16];
  assign ri = ovl_data[IW-1:0];
  assign bs = best_r[IW+15 -: 16];
  assign bi = best_r[IW-1:0];

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    ovf_nxt        = ovf_r;
    cnt_nxt        = cnt_r;
    has_kept_nxt   = has_kept_r;
    kept_nxt       = kept_r;
    best_found_nxt = best_found_r;
    best_nxt       = best_r;
    push           = 1'b0;
    push_none      = 1'b0;
    push_last      = 1'b0;
    clear          = 1'b0;

    // running best of the surviving boxes in this pass
    if (ovl_vld && ovl_keep &&
        (!best_found_r || rs > bs || (rs == bs && ri < bi))) begin
      best_found_nxt = 1'b1;
      best_nxt       = ovl_data;
    end

    case (state_r)
      ST_LOAD: begin
        if (in_acc) begin
          if (store) begin
            count_nxt = count_r + CW'(1);
          end else if (in_ch.present) begin
            ovf_nxt = 1'b1;
          end
          if (in_ch.last_box) begin
            if (count_r == '0 && !store) begin
              state_nxt = ST_NONE;
            end else begin
              state_nxt      = ST_SCAN;
              cnt_nxt        = '0;
              best_found_nxt = 1'b0;
            end
          end
        end
      end
      ST_SCAN: begin
        cnt_nxt = cnt_r + NW'(1);
        if (cnt_r == NW'(SCAN_LAST)) begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (best_found_r) begin
          if (!has_kept_r || out_free) begin
            push           = has_kept_r;
            kept_nxt       = best_r;
            has_kept_nxt   = 1'b1;
            best_found_nxt = 1'b0;
            cnt_nxt        = '0;
            state_nxt      = ST_SCAN;
          end
        end else if (out_free) begin
          push      = 1'b1;
          push_last = 1'b1;
          clear     = 1'b1;
        end
      end
      ST_NONE: begin
        if (out_free) begin
          push      = 1'b1;
          push_none = 1'b1;
          push_last = 1'b1;
          clear     = 1'b1;
        end
      end
      default: state_nxt = ST_LOAD;
    endcase

    if (clear) begin
      state_nxt    = ST_LOAD;
      count_nxt    = '0;
      ovf_nxt      = 1'b0;
      has_kept_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_LOAD;
      count_r      <= '0;
      ovf_r        <= 1'b0;
      thr_r        <= THRESH_RESET;
      cnt_r        <= '0;
      has_kept_r   <= 1'b0;
      best_found_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      ovf_r        <= ovf_nxt;
      cnt_r        <= cnt_nxt;
      has_kept_r   <= has_kept_nxt;
      best_found_r <= best_found_nxt;
      if (cfg_ch.valid) begin
        thr_r <= cfg_ch.data;
      end
      if (push) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
    kept_r <= kept_nxt;
    best_r <= best_nxt;
    if (push) begin
      onone_r <= push_none;
      oovf_r  <= ovf_r;
      olast_r <= push_last;
      if (push_none) begin
        ox_r <= '0;
        oy_r <= '0;
        ow_r <= '0;
        oh_r <= '0;
        os_r <= '0;
        oi_r <= '0;
      end else begin
        ox_r <= COORD_W'(kept_r[W-1 -: C]);
        oy_r <= COORD_W'(kept_r[W-1-C -: C]);
        ow_r <= COORD_W'(kept_r[W-1-2*C -: C]);
        oh_r <= COORD_W'(kept_r[W-1-3*C -: C]);
        os_r <= kept_r[IW+15 -: 16];
        oi_r <= KIDX_W'(kept_r[IW-1:0]);
      end
    end
  end

  assign in_ch.ready       = (state_r == ST_LOAD);
  assign cfg_ch.ready      = 1'b1;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.kept_x     = ox_r;
  assign out_ch.kept_y     = oy_r;
  assign out_ch.kept_w     = ow_r;
  assign out_ch.kept_h     = oh_r;
  assign out_ch.kept_score = os_r;
  assign out_ch.kept_index = oi_r;
  assign out_ch.none_kept  = onone_r;
  assign out_ch.overflow   = oovf_r;
  assign out_ch.last_kept  = olast_r;

endmodule

FILE: test/tb_ifs.sv
// Testbench-side copies are not needed: the RTL interfaces are reused directly.
// This file only holds the result record shared by the test tasks.
package tb_nms_pkg;
  typedef struct packed {
    logic [11:0] x;
    logic [11:0] y;
    logic [11:0] w;
    logic [11:0] h;
    logic [15:0] score;
    logic [4:0]  index;
    logic        none_kept;
    logic        overflow;
    logic        last_kept;
  } kept_box_t;
endpackage

FILE: test/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import bnms_pkg::*;
  import tb_nms_pkg::*;

  localparam int CAP = 32;
  localparam int WATCHDOG_LIMIT = 20000;

  logic clk;
  logic rst_n;

  bnms_in_if  in_ch ();
  bnms_out_if out_ch ();
  bnms_cfg_if cfg_ch ();

  box_non_maximum_suppression #(.MAX_BOXES(CAP), .COORD_BITS(COORD_W)) dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // predictor state
  logic [11:0] st_x [CAP];
  logic [11:0] st_y [CAP];
  logic [11:0] st_w [CAP];
  logic [11:0] st_h [CAP];
  logic [15:0] st_s [CAP];
  int          frame_count;
  logic        frame_ovf;
  logic [15:0] iou_thresh;

  kept_box_t kept_queue[$];
  int        errors;
  int        idle_cycles;
  bit        out_stall_on;
  bit        in_gap_on;

  function automatic bit suppresses(int a, int b);
    longint unsigned x0, y0, x1, y1, inter, uni;
    x0 = (st_x[a] > st_x[b]) ? 64'(st_x[a]) : 64'(st_x[b]);
    y0 = (st_y[a] > st_y[b]) ? 64'(st_y[a]) : 64'(st_y[b]);
    x1 = ((64'(st_x[a]) + 64'(st_w[a])) < (64'(st_x[b]) + 64'(st_w[b]))) ?
         64'(st_x[a]) + 64'(st_w[a]) : 64'(st_x[b]) + 64'(st_w[b]);
    y1 = ((64'(st_y[a]) + 64'(st_h[a])) < (64'(st_y[b]) + 64'(st_h[b]))) ?
         64'(st_y[a]) + 64'(st_h[a]) : 64'(st_y[b]) + 64'(st_h[b]);
    if (x1 <= x0 || y1 <= y0) return 1'b0;
    inter = (x1 - x0) * (y1 - y0);
    uni = 64'(st_w[a]) * 64'(st_h[a]) + 64'(st_w[b]) * 64'(st_h[b]) - inter;
    return inter * 64'd65536 > 64'(iou_thresh) * uni;
  endfunction

  task automatic queue_result(kept_box_t r);
    kept_queue = {kept_queue, r};
  endtask

  task automatic predict_frame_end();
    bit        taken [CAP];
    bit        supp [CAP];
    int        order [CAP];
    int        best;
    int        idx;
    kept_box_t r;
    for (int i = 0; i < CAP; i++) begin
      taken[i] = 0;
      supp[i] = 0;
    end
    if (frame_count == 0) begin
      r = '0;
      r.none_kept = 1'b1;
      r.overflow = frame_ovf;
      r.last_kept = 1'b1;
      queue_result(r);
    end else begin
      for (int k = 0; k < frame_count; k++) begin
        best = -1;
        for (int i = 0; i < frame_count; i++)
          if (!taken[i] && (best < 0 || st_s[i] > st_s[best])) best = i;
        taken[best] = 1;
        order[k] = best;
      end
      for (int k = 0; k < frame_count; k++) begin
        idx = order[k];
        if (supp[idx]) continue;
        r = '0;
        r.x = st_x[idx];
        r.y = st_y[idx];
        r.w = st_w[idx];
        r.h = st_h[idx];
        r.score = st_s[idx];
        r.index = idx[4:0];
        r.overflow = frame_ovf;
        queue_result(r);
        for (int j = 0; j < frame_count; j++)
          if (j != idx && !supp[j] && suppresses(idx, j)) supp[j] = 1;
      end
      kept_queue[$].last_kept = 1'b1;
    end
    frame_count = 0;
    frame_ovf = 1'b0;
  endtask

  task automatic predict_box(logic [11:0] x, logic [11:0] y, logic [11:0] w, logic [11:0] h,
                             logic [15:0] s, logic present, logic last);
    if (present) begin
      if (frame_count < CAP) begin
        st_x[frame_count] = x;
        st_y[frame_count] = y;
        st_w[frame_count] = w;
        st_h[frame_count] = h;
        st_s[frame_count] = s;
        frame_count++;
      end else begin
        frame_ovf = 1'b1;
      end
    end
    if (last) predict_frame_end();
  endtask

  // entered at a falling edge; valid stays high so items can go back to back
  task automatic send_box(logic [11:0] x, logic [11:0] y, logic [11:0] w, logic [11:0] h,
                          logic [15:0] s, logic present, logic last);
    while (in_gap_on && $urandom_range(99) < 21) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.box_x    <= x;
    in_ch.box_y    <= y;
    in_ch.box_w    <= w;
    in_ch.box_h    <= h;
    in_ch.score    <= s;
    in_ch.present  <= present;
    in_ch.last_box <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_box(x, y, w, h, s, present, last);
    @(negedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (kept_queue.size() != 0) @(negedge clk);
    repeat (10 * (CAP + 6)) @(negedge clk);
  endtask

  task automatic write_threshold(logic [15:0] value);
    drain();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    iou_thresh = value;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic send_random_box(logic last, int spread);
    send_box(12'($urandom_range(spread)), 12'($urandom_range(spread)),
             12'($urandom_range(spread / 2)), 12'($urandom_range(spread / 2)),
             16'($urandom()), 1'b1, last);
  endtask

  task automatic test_directed();
    // field extremes, overlapping pair, disjoint box and zero-area box
    send_box(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 16'hFFFF, 1'b1, 1'b0);
    send_box(12'd0, 12'd0, 12'd0, 12'd0, 16'd0, 1'b1, 1'b1);
    send_box(12'd10, 12'd10, 12'd100, 12'd100, 16'd500, 1'b1, 1'b0);
    send_box(12'd12, 12'd12, 12'd100, 12'd100, 16'd500, 1'b1, 1'b0);
    send_box(12'd500, 12'd500, 12'd20, 12'd20, 16'd900, 1'b1, 1'b0);
    send_box(12'd15, 12'd15, 12'd0, 12'd50, 16'd100, 1'b1, 1'b0);
    send_box(12'd0, 12'd0, 12'd0, 12'd0, 16'd0, 1'b0, 1'b1);
    // empty frame
    send_box(12'hAAA, 12'h555, 12'hAAA, 12'h555, 16'hAAAA, 1'b0, 1'b1);
  endtask

  task automatic test_overflow();
    for (int i = 0; i < CAP + 2; i++) send_random_box(1'b0, 4095);
    send_box(12'd1, 12'd2, 12'd3, 12'd4, 16'd5, 1'b1, 1'b1);
  endtask

  task automatic test_thresholds();
    write_threshold(16'd0);
    for (int i = 0; i < 6; i++) send_random_box(i == 5, 300);
    write_threshold(16'hFFFF);
    for (int i = 0; i < 6; i++) send_random_box(i == 5, 300);
    write_threshold(THRESH_RESET);
  endtask

  task automatic test_random_frames();
    int n;
    int sent;
    bit paused;
    sent = 0;
    paused = 1'b0;
    while (sent < 225) begin
      if (sent > 100 && sent < 160) begin
        out_stall_on = 1'b0;
        in_gap_on = 1'b0;
      end else begin
        out_stall_on = 1'b1;
        in_gap_on = 1'b1;
      end
      if (sent > 180 && sent < 195) write_threshold(16'($urandom()));
      n = ($urandom_range(9) == 0) ? $urandom_range(CAP) : $urandom_range(6);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(9) == 0)
          send_box(12'($urandom()), 12'($urandom()), 12'($urandom()), 12'($urandom()),
                   16'($urandom()), 1'b0, 1'b0);
        else
          send_random_box(1'b0, ($urandom_range(1)) ? 400 : 4095);
      end
      send_box(12'($urandom()), 12'($urandom()), 12'($urandom_range(200)),
               12'($urandom_range(200)), 16'($urandom()), 1'($urandom_range(1)), 1'b1);
      sent += n + 1;
      // hold off until the frame has fully drained
      if (!paused && sent > 60) begin
        drain();
        paused = 1'b1;
      end
    end
  endtask

  // result checker
  always @(posedge clk) begin
    kept_box_t got, exp;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.kept_x, out_ch.kept_y, out_ch.kept_w, out_ch.kept_h, out_ch.kept_score,
              out_ch.kept_index, out_ch.none_kept, out_ch.overflow, out_ch.last_kept};
      if (kept_queue.size() == 0) begin
        $display("%0t unexpected result: actual %p", $realtime, got);
        errors++;
      end else begin
        exp = kept_queue.pop_front();
        if (got !== exp) begin
          $display("%0t kept box mismatch: expected %p actual %p", $realtime, exp, got);
          errors++;
        end
      end
    end
  end

  always @(negedge clk)
    out_ch.ready <= !(out_stall_on && $urandom_range(99) < 21);

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    errors = 0;
    idle_cycles = 0;
    frame_count = 0;
    frame_ovf = 1'b0;
    iou_thresh = THRESH_RESET;
    out_stall_on = 1'b1;
    in_gap_on = 1'b1;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.box_x = '0;
    in_ch.box_y = '0;
    in_ch.box_w = '0;
    in_ch.box_h = '0;
    in_ch.score = '0;
    in_ch.present = 1'b0;
    in_ch.last_box = 1'b0;
    out_ch.ready = 1'b1;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_overflow();
    test_thresholds();
    test_random_frames();
    drain();
    if (errors == 0 && kept_queue.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

FILE: sim.f
sv/bnms_pkg.sv
sv/bnms_if.sv
sv/bnms_cell.sv
sv/bnms_ovl.sv
sv/box_non_maximum_suppression.sv
test/tb_ifs.sv
test/tb_top.sv
